// ----- rtl/four_way_min_heap_queue_top_assert.svh -----
// Assertion macros for the four-way min-heap queue.
// Used by the top level only; needs i_clk and i_rst_n in scope.
`ifndef FOUR_WAY_MIN_HEAP_QUEUE_TOP_ASSERT_SVH
`define FOUR_WAY_MIN_HEAP_QUEUE_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define FWMHQ_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("heap queue check failed");
`define FWMHQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");
`else
`define FWMHQ_ASSERT_HOLDS(lbl, cond)
`define FWMHQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/fwmhq_pkg.sv -----
// Shared types and constants for the four-way min-heap queue.
// No dependencies.
`default_nettype none
package fwmhq_pkg;
    localparam int unsigned CAPACITY_DEF = 256;
    localparam int unsigned KEY_W        = 32;
    localparam int unsigned PAY_W        = 16;
    localparam int unsigned COUNT_W      = 9;
    localparam int unsigned ARITY        = 4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_entry;

    typedef enum logic [1:0] {
        STAT_INSERTED  = 2'd0,
        STAT_EXTRACTED = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_EX_RD0, S_EX_RDL, S_EX_LAST,
        S_DN, S_DN_WR, S_FIN
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/fwmhq_in_if.sv -----
// Input channel of the heap queue: valid, ready and one request word.
// Depends on fwmhq_pkg.
`default_nettype none
interface fwmhq_in_if;
    import fwmhq_pkg::*;
    logic             valid;
    logic             ready;
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    modport source (output valid, mode, key, payload, input ready);
    modport sink   (input valid, mode, key, payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/fwmhq_out_if.sv -----
// Output channel of the heap queue: valid, ready and one result word.
// Depends on fwmhq_pkg.
`default_nettype none
interface fwmhq_out_if;
    import fwmhq_pkg::*;
    logic               valid;
    logic               ready;
    logic [KEY_W-1:0]   out_key;
    logic [PAY_W-1:0]   out_payload;
    logic [1:0]         status;
    logic [COUNT_W-1:0] entry_count;
    modport source (output valid, out_key, out_payload, status, entry_count, input ready);
    modport sink   (input valid, out_key, out_payload, status, entry_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/fwmhq_ram.sv -----
// Entry storage of the heap: one write port, one read port, registered read.
// Depends on fwmhq_pkg.
`default_nettype none
module fwmhq_ram #(
    parameter int unsigned DEPTH = fwmhq_pkg::CAPACITY_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire fwmhq_pkg::t_entry i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output      fwmhq_pkg::t_entry o_rdata
);
    import fwmhq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- rtl/four_way_min_heap_queue_top.sv -----
// Four-way min-heap priority queue, top level.
// Depends on fwmhq_pkg, fwmhq_in_if, fwmhq_out_if, fwmhq_ram and the assert header.
//
// Usage: each word on i_in is an insert (mode 0, key and payload) or an
// extract of the minimum (mode 1). Every accepted word yields exactly one
// result word on o_out with the extracted entry (zero for inserts), a
// status (inserted, extracted, empty on extract, full on insert) and the
// entry count after the operation. Entries with equal keys never swap.
// One word is processed at a time; i_in.ready is high while the block idles.
// Steps: an insert reads and compares the parent once per level moved up,
// sliding a larger parent down, and writes itself where it stops. An
// extract reads the root, then the last entry, and ends there when that
// empties the queue; otherwise each level moved down does up to four child
// reads through the single registered read port, the last compares, then
// one write-back. Rejected words go straight to the final step.
// A finished result sits in an output register, so the next word is
// accepted while it waits; if the receiver stalls with a result already
// held, the block waits in its final step until the register frees up.
// Reset empties the queue at once (fill count zero); no memory clear runs.
`default_nettype none
module four_way_min_heap_queue_top #(
    parameter int unsigned CAPACITY = fwmhq_pkg::CAPACITY_DEF
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    fwmhq_in_if.sink   i_in,
    fwmhq_out_if.source o_out
);
    import fwmhq_pkg::*;
    `include "four_way_min_heap_queue_top_assert.svh"

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned KW = AW + 3;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic [AW-1:0]   r_pos, n_pos;
    t_entry          r_cur, n_cur;
    t_entry          r_best, n_best;
    logic [AW-1:0]   r_bidx, n_bidx;
    logic [2:0]      r_cnt, n_cnt;
    logic            r_rv, n_rv;
    logic [AW-1:0]   r_ridx, n_ridx;
    t_entry          r_res, n_res;
    t_status         r_stat, n_stat;

    logic               r_ov;
    t_entry             r_oent;
    t_status            r_ostat;
    logic [COUNT_W-1:0] r_ocnt;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic          out_load;
    logic [KW-1:0] kid;
    logic [CW+COUNT_W-1:0] fill_ext;
    logic          in_ins_ok;

    fwmhq_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign kid      = ({3'b000, r_pos} << 2) + KW'(r_cnt);
    assign fill_ext = {{COUNT_W{1'b0}}, r_fill};
    assign i_in.ready = (r_state == S_IDLE);
    assign in_ins_ok = i_in.valid && i_in.ready && !i_in.mode && (r_fill != CW'(CAPACITY));

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_best    = r_best;
        n_bidx    = r_bidx;
        n_cnt     = r_cnt;
        n_rv      = 1'b0;
        n_ridx    = r_ridx;
        n_res     = r_res;
        n_stat    = r_stat;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_cur;
        mem_raddr = '0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_res = '0;
                    if (!i_in.mode) begin
                        if (r_fill == CW'(CAPACITY)) begin
                            n_stat  = STAT_FULL;
                            n_state = S_FIN;
                        end else begin
                            n_stat  = STAT_INSERTED;
                            n_cur   = '{key: i_in.key, payload: i_in.payload};
                            n_pos   = AW'(r_fill);
                            n_fill  = r_fill + 1'b1;
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_fill == '0) begin
                            n_stat  = STAT_EMPTY;
                            n_state = S_FIN;
                        end else begin
                            n_stat  = STAT_EXTRACTED;
                            n_fill  = r_fill - 1'b1;
                            n_state = S_EX_RD0;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    mem_raddr = (r_pos - 1'b1) >> 2;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // The moving entry stays in r_cur; a larger parent slides down.
                mem_we = 1'b1;
                if (mem_rdata.key > r_cur.key) begin
                    mem_wdata = mem_rdata;
                    n_pos     = (r_pos - 1'b1) >> 2;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_EX_RD0: begin
                mem_raddr = '0;
                n_state   = S_EX_RDL;
            end
            S_EX_RDL: begin
                n_res     = mem_rdata;
                mem_raddr = AW'(r_fill);
                n_state   = S_EX_LAST;
            end
            S_EX_LAST: begin
                n_cur  = mem_rdata;
                n_best = mem_rdata;
                n_pos  = '0;
                n_bidx = '0;
                n_cnt  = 3'd1;
                n_state = (r_fill == '0) ? S_FIN : S_DN;
            end
            S_DN: begin
                // Child reads are issued back to back; each compare lands in the cycle after its read.
                if (r_cnt <= 3'd4) begin
                    if (kid < KW'(r_fill)) begin
                        mem_raddr = AW'(kid);
                        n_rv      = 1'b1;
                        n_ridx    = AW'(kid);
                    end
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_rv && (mem_rdata.key < r_best.key)) begin
                    n_best = mem_rdata;
                    n_bidx = r_ridx;
                end
                if (r_cnt == 3'd5 && !r_rv) begin
                    n_state = S_DN_WR;
                end
            end
            S_DN_WR: begin
                mem_we = 1'b1;
                if (r_bidx == r_pos) begin
                    n_state = S_FIN;
                end else begin
                    mem_wdata = r_best;
                    n_pos     = r_bidx;
                    n_best    = r_cur;
                    n_cnt     = 3'd1;
                    n_state   = S_DN;
                end
            end
            S_FIN: begin
                if (!r_ov || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_rv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_rv    <= n_rv;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_cur  <= n_cur;
        r_best <= n_best;
        r_bidx <= n_bidx;
        r_cnt  <= n_cnt;
        r_ridx <= n_ridx;
        r_res  <= n_res;
        r_stat <= n_stat;
        if (out_load) begin
            r_oent  <= r_res;
            r_ostat <= r_stat;
            r_ocnt  <= fill_ext[COUNT_W-1:0];
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_key     = r_oent.key;
    assign o_out.out_payload = r_oent.payload;
    assign o_out.status      = r_ostat;
    assign o_out.entry_count = r_ocnt;

    `FWMHQ_ASSERT_HOLDS(a_fill_bound, r_fill <= CW'(CAPACITY))
    `FWMHQ_ASSERT_NEXT(a_insert_count, in_ins_ok, r_fill == $past(r_fill) + 1'b1)
    `FWMHQ_ASSERT_HOLDS(a_scan_count, r_state != S_DN || r_cnt <= 3'd5)
    `FWMHQ_ASSERT_NEXT(a_load_valid, out_load, r_ov && r_state == S_IDLE)
endmodule
`default_nettype wire

// ----- tb/four_way_min_heap_queue_top_tb.sv -----
// Self-checking testbench for the four-way min-heap queue top level.
// Depends on fwmhq_pkg, fwmhq_in_if, fwmhq_out_if and the RTL top level.
`default_nettype none
module four_way_min_heap_queue_top_tb;
    import fwmhq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH     = CAPACITY_DEF;
    localparam int unsigned MODE_INS  = 0;
    localparam int unsigned MODE_EXT  = 1;
    localparam int          MAX_CYCLE = 2000000;

    typedef struct packed {
        logic [KEY_W-1:0]   out_key;
        logic [PAY_W-1:0]   out_payload;
        t_status            status;
        logic [COUNT_W-1:0] entry_count;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    fwmhq_in_if  in_ch ();
    fwmhq_out_if out_ch ();

    four_way_min_heap_queue_top #(.CAPACITY(DEPTH)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Shadow heap used to predict each result word.
    logic [KEY_W-1:0] hkeys [DEPTH];
    logic [PAY_W-1:0] hpays [DEPTH];
    int unsigned      hfill;

    t_result results_due[$];
    int      mismatches;
    int      cycle_count;
    int      hold_off;     // receiver forced stall, in cycles
    bit      rx_quiet;     // receiver stalls only for hold_off while set

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("four_way_min_heap_queue_top_tb NOT OK");
            $finish;
        end
    end

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [KEY_W-1:0] k;
        logic [PAY_W-1:0] p;
        k = hkeys[a]; p = hpays[a];
        hkeys[a] = hkeys[b]; hpays[a] = hpays[b];
        hkeys[b] = k; hpays[b] = p;
    endfunction

    function automatic t_result heap_apply(logic mode, logic [KEY_W-1:0] key,
                                           logic [PAY_W-1:0] pay);
        t_result     r;
        int unsigned pos, best, kid, up;
        r = '0;
        if (mode == MODE_INS[0]) begin
            if (hfill >= DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                hkeys[hfill] = key;
                hpays[hfill] = pay;
                pos = hfill;
                hfill++;
                while (pos > 0) begin
                    up = (pos - 1) / ARITY;
                    if (hkeys[up] > hkeys[pos]) begin
                        swap_slots(up, pos);
                        pos = up;
                    end else break;
                end
                r.status = STAT_INSERTED;
            end
        end else begin
            if (hfill == 0) begin
                r.status = STAT_EMPTY;
            end else begin
                r.out_key = hkeys[0];
                r.out_payload = hpays[0];
                hfill--;
                hkeys[0] = hkeys[hfill];
                hpays[0] = hpays[hfill];
                pos = 0;
                forever begin
                    best = pos;
                    for (int c = 1; c <= ARITY; c++) begin
                        kid = pos * ARITY + c;
                        if (kid < hfill && hkeys[kid] < hkeys[best]) best = kid;
                    end
                    if (best == pos) break;
                    swap_slots(best, pos);
                    pos = best;
                end
                r.status = STAT_EXTRACTED;
            end
        end
        r.entry_count = hfill[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Sends one request word and records the result it must produce.
    // The valid line stays high after acceptance; a gap or drain lowers it.
    task automatic send_word(logic mode, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay,
                             bit gaps = 1'b1);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= mode;
        in_ch.key     <= key;
        in_ch.payload <= pay;
        do @(posedge i_clk); while (!in_ch.ready);
        results_due = {results_due, heap_apply(mode, key, pay)};
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (hold_off > 0) hold_off <= hold_off - 1;
            out_ch.ready <= (hold_off <= 1) &&
                            (rx_quiet || $urandom_range(0, 3) != 0);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.out_key, out_ch.out_payload, t_status'(out_ch.status),
                    out_ch.entry_count};
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
            end else begin
                want = results_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: key %h/%h pay %h/%h status %0d/%0d count %0d/%0d",
                                 want.out_key, got.out_key, want.out_payload,
                                 got.out_payload, want.status, got.status,
                                 want.entry_count, got.entry_count);
                end
            end
        end
    end

    task automatic test_edges();
        send_word(MODE_EXT[0], '1, '1);
        send_word(MODE_INS[0], '1, '1);
        send_word(MODE_INS[0], '0, '0);
        send_word(MODE_INS[0], 32'd5, 16'h1111);
        send_word(MODE_INS[0], 32'd5, 16'h2222);
        send_word(MODE_INS[0], 32'd5, 16'h3333);
        send_word(MODE_INS[0], 32'h8000_0000, 16'h8000);
        for (int i = 0; i < 9; i++) send_word(MODE_EXT[0], 32'd0, 16'd0);
        drain();
    endtask

    task automatic test_full();
        for (int i = 0; i < DEPTH + 3; i++)
            send_word(MODE_INS[0], $urandom_range(0, 15), 16'($urandom), 1'b0);
        for (int i = 0; i < DEPTH + 2; i++)
            send_word(MODE_EXT[0], $urandom, 16'($urandom), i[0]);
        drain();
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        for (int i = 0; i < 40; i++)
            send_word($urandom_range(0, 2) == 0, $urandom, 16'($urandom), 1'b0);
        drain();
    endtask

    task automatic test_random(int n);
        logic [KEY_W-1:0] k;
        for (int i = 0; i < n; i++) begin
            rx_quiet = (i % 300) < 60;
            case ($urandom_range(0, 3))
                0: k = $urandom;
                1: k = $urandom_range(0, 7);
                2: k = {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
                default: k = $urandom_range(0, 1000);
            endcase
            // Bias toward inserts while low, extracts while high.
            if (hfill < 100) send_word($urandom_range(0, 9) < 4, k, 16'($urandom));
            else send_word($urandom_range(0, 9) < 6, k, 16'($urandom));
        end
        rx_quiet = 1'b0;
        drain();
    endtask

    initial begin
        mismatches    = 0;
        cycle_count   = 0;
        hold_off      = 0;
        rx_quiet      = 1'b0;
        hfill         = 0;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.mode    = 1'b0;
        in_ch.key     = '0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges();
        test_full();
        test_backpressure();
        test_random(1330);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("four_way_min_heap_queue_top_tb OK");
        end else begin
            $display("four_way_min_heap_queue_top_tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/fwmhq_pkg.sv
rtl/fwmhq_in_if.sv
rtl/fwmhq_out_if.sv
rtl/fwmhq_ram.sv
rtl/four_way_min_heap_queue_top.sv
tb/four_way_min_heap_queue_top_tb.sv
